// ----- hdl/flow_grid_bilinear_warp_defines.svh -----
// ----------------------------------------------------------------------------
// flow_grid_bilinear_warp_defines
// Assertion macros shared by the warp block.
// ----------------------------------------------------------------------------
`ifndef FLOW_GRID_BILINEAR_WARP_DEFINES_SVH
`define FLOW_GRID_BILINEAR_WARP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define FGBW_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("fgbw: implication failed");

// Next-cycle implication, disabled during reset.
`define FGBW_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("fgbw: next-cycle implication failed");

// Full property, disabled during reset.
`define FGBW_ASSERT_PROP(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("fgbw: property failed");

`endif

// ----- hdl/fgbw_pkg.sv -----
// ----------------------------------------------------------------------------
// fgbw_pkg
// Types and constants of the displacement-grid warp block.
// ----------------------------------------------------------------------------
package fgbw_pkg;

	localparam int GridWidth  = 16;
	localparam int GridHeight = 16;
	localparam int FracBits   = 16;
	localparam int DispShift  = 8;
	localparam int DispWidth  = 24;
	localparam int CoordWidth = 32;
	localparam int IndexWidth = 8;
	localparam int UnitWidth  = FracBits + 1;
	localparam logic [UnitWidth-1:0] UnitOne = UnitWidth'(32'h0001_0000);

	typedef enum logic {
		FuncWrite  = 1'b0,
		FuncSample = 1'b1
	} func_t;

	typedef struct packed {
		func_t                         func;
		logic [IndexWidth-1:0]         entry_index;
		logic signed [DispWidth-1:0]   disp_x;
		logic signed [DispWidth-1:0]   disp_y;
		logic signed [CoordWidth-1:0]  coord_u;
		logic signed [CoordWidth-1:0]  coord_v;
	} in_item_t;

	typedef struct packed {
		logic signed [CoordWidth-1:0] warped_u;
		logic signed [CoordWidth-1:0] warped_v;
	} out_item_t;

endpackage

// ----- hdl/fgbw_mem.sv -----
// ----------------------------------------------------------------------------
// fgbw_mem
// One-write, one-read grid memory with registered read data.
// ----------------------------------------------------------------------------
module fgbw_mem #(
	parameter int DEPTH      = 256,
	parameter int ADDR_WIDTH = 8,
	parameter int DATA_WIDTH = 48
) (
	input  logic                  clk,
	input  logic                  wr_en,
	input  logic [ADDR_WIDTH-1:0] wr_addr,
	input  logic [DATA_WIDTH-1:0] wr_data,
	input  logic [ADDR_WIDTH-1:0] rd_addr,
	output logic [DATA_WIDTH-1:0] rd_data
);

	logic [DATA_WIDTH-1:0] mem [DEPTH];
	logic [DATA_WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_q <= mem[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

// ----- hdl/fgbw_axis.sv -----
// ----------------------------------------------------------------------------
// fgbw_axis
// Clamps one coordinate to the unit range, scales it to the grid and splits
// it into a cell index, the far neighbor index and a 16-bit fraction.
// ----------------------------------------------------------------------------
module fgbw_axis #(
	parameter int SIZE      = fgbw_pkg::GridWidth,
	parameter int IDX_WIDTH = $clog2(SIZE)
) (
	input  logic                                   clk,
	input  logic signed [fgbw_pkg::CoordWidth-1:0] coord,
	output logic [IDX_WIDTH-1:0]                   g0,
	output logic [IDX_WIDTH-1:0]                   g1,
	output logic [fgbw_pkg::FracBits-1:0]          frac
);

	localparam int ProdWidth = fgbw_pkg::UnitWidth + IDX_WIDTH;
	localparam logic [IDX_WIDTH-1:0] LastIdx = IDX_WIDTH'(SIZE - 1);

	logic [fgbw_pkg::UnitWidth-1:0] clamped;
	logic [ProdWidth-1:0]           scaled;
	logic [IDX_WIDTH-1:0]           lo_idx;
	logic [IDX_WIDTH-1:0]           hi_idx;
	logic [IDX_WIDTH-1:0]           g0_s2;
	logic [IDX_WIDTH-1:0]           g1_s2;
	logic [fgbw_pkg::FracBits-1:0]  frac_s2;

	always_comb begin
		if (coord <= 0) begin
			clamped = '0;
		end else if (coord >= $signed({15'd0, fgbw_pkg::UnitOne})) begin
			clamped = fgbw_pkg::UnitOne;
		end else begin
			clamped = coord[fgbw_pkg::UnitWidth-1:0];
		end
		scaled = ProdWidth'(clamped) * ProdWidth'(SIZE - 1);
		lo_idx = scaled[fgbw_pkg::FracBits +: IDX_WIDTH];
		hi_idx = (lo_idx == LastIdx) ? lo_idx : IDX_WIDTH'(lo_idx + 1'b1);
	end

	always_ff @(posedge clk) begin
		g0_s2   <= lo_idx;
		g1_s2   <= hi_idx;
		frac_s2 <= scaled[fgbw_pkg::FracBits-1:0];
	end

	assign g0   = g0_s2;
	assign g1   = g1_s2;
	assign frac = frac_s2;

endmodule

// ----- hdl/fgbw_lerp.sv -----
// ----------------------------------------------------------------------------
// fgbw_lerp
// Registered linear blend a + floor((b - a) * t / 2^16).
// ----------------------------------------------------------------------------
module fgbw_lerp (
	input  logic                                  clk,
	input  logic signed [fgbw_pkg::DispWidth-1:0] a,
	input  logic signed [fgbw_pkg::DispWidth-1:0] b,
	input  logic [fgbw_pkg::FracBits-1:0]         t,
	output logic signed [fgbw_pkg::DispWidth-1:0] y
);

	localparam int DiffWidth = fgbw_pkg::DispWidth + 1;
	localparam int TWidth    = fgbw_pkg::FracBits + 1;
	localparam int ProdWidth = DiffWidth + TWidth;
	localparam int StepWidth = ProdWidth - fgbw_pkg::FracBits;

	logic signed [DiffWidth-1:0] diff;
	logic signed [TWidth-1:0]    t_sgn;
	logic signed [ProdWidth-1:0] prod;
	logic signed [StepWidth-1:0] step;
	logic signed [StepWidth-1:0] sum;
	logic signed [fgbw_pkg::DispWidth-1:0] y_q;

	always_comb begin
		diff  = {b[fgbw_pkg::DispWidth-1], b} - {a[fgbw_pkg::DispWidth-1], a};
		t_sgn = {1'b0, t};
		prod  = diff * t_sgn;
		// dropping the low bits of a two's complement value floors it
		step  = prod[ProdWidth-1:fgbw_pkg::FracBits];
		sum   = StepWidth'(a) + step;
	end

	always_ff @(posedge clk) begin
		y_q <= sum[fgbw_pkg::DispWidth-1:0];
	end

	assign y = y_q;

endmodule

// ----- hdl/flow_grid_bilinear_warp.sv -----
// ----------------------------------------------------------------------------
// flow_grid_bilinear_warp
// Bilinear displacement-grid warp of signed 16.16 coordinate pairs.
// ----------------------------------------------------------------------------
// One command is taken every clock cycle; busy is always low. A sample
// command gives its result strobe from the result register, in
// command order, with no back-pressure from the receiver. A grid write
// produces no result and is seen by every sample taken after it. The four
// corner reads come from four copies of the grid memory, each with one
// read port, written together; the path is clamp/scale, memory read,
// horizontal blend, vertical blend, and final add. Reads of entries never
// written return whatever the memory holds.
// ----------------------------------------------------------------------------
`include "flow_grid_bilinear_warp_defines.svh"

module flow_grid_bilinear_warp #(
	parameter int GRID_WIDTH  = fgbw_pkg::GridWidth,
	parameter int GRID_HEIGHT = fgbw_pkg::GridHeight
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  fgbw_pkg::in_item_t  cmd,
	output logic                result_valid,
	output fgbw_pkg::out_item_t result
);

	localparam int CellCount = GRID_WIDTH * GRID_HEIGHT;
	localparam int AddrWidth = $clog2(CellCount);
	localparam int XWidth    = $clog2(GRID_WIDTH);
	localparam int YWidth    = $clog2(GRID_HEIGHT);
	localparam int DW        = fgbw_pkg::DispWidth;
	localparam int CW        = fgbw_pkg::CoordWidth;
	localparam int FW        = fgbw_pkg::FracBits;
	localparam int EntryBits = 2 * DW;

	logic accept;

	// stage 1
	logic               v_s1;
	fgbw_pkg::in_item_t cmd_s1;

	// stage 2
	logic                          v_s2;
	fgbw_pkg::func_t               func_s2;
	logic [fgbw_pkg::IndexWidth-1:0] idx_s2;
	logic signed [DW-1:0]          dx_s2;
	logic signed [DW-1:0]          dy_s2;
	logic signed [CW-1:0]          cu_s2;
	logic signed [CW-1:0]          cv_s2;
	logic [XWidth-1:0]             gx0_s2;
	logic [XWidth-1:0]             gx1_s2;
	logic [YWidth-1:0]             gy0_s2;
	logic [YWidth-1:0]             gy1_s2;
	logic [FW-1:0]                 tx_s2;
	logic [FW-1:0]                 ty_s2;

	logic                  wr_en;
	logic [AddrWidth-1:0]  wr_addr;
	logic [EntryBits-1:0]  wr_data;
	logic [AddrWidth-1:0]  rd_addr [4];
	logic [EntryBits-1:0]  rd_data [4];

	// stage 3
	logic                 v_s3;
	logic [FW-1:0]        tx_s3;
	logic [FW-1:0]        ty_s3;
	logic signed [CW-1:0] cu_s3;
	logic signed [CW-1:0] cv_s3;

	// stage 4
	logic                 v_s4;
	logic [FW-1:0]        ty_s4;
	logic signed [CW-1:0] cu_s4;
	logic signed [CW-1:0] cv_s4;
	logic signed [DW-1:0] top_x_s4;
	logic signed [DW-1:0] top_y_s4;
	logic signed [DW-1:0] bot_x_s4;
	logic signed [DW-1:0] bot_y_s4;

	// stage 5
	logic                 v_s5;
	logic signed [CW-1:0] cu_s5;
	logic signed [CW-1:0] cv_s5;
	logic signed [DW-1:0] fx_s5;
	logic signed [DW-1:0] fy_s5;

	// stage 6 (result register)
	logic                 v_s6;
	fgbw_pkg::out_item_t  res_s6;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2 && (func_s2 == fgbw_pkg::FuncSample);
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1 <= cmd;
		end
		func_s2 <= cmd_s1.func;
		idx_s2  <= cmd_s1.entry_index;
		dx_s2   <= cmd_s1.disp_x;
		dy_s2   <= cmd_s1.disp_y;
		cu_s2   <= cmd_s1.coord_u;
		cv_s2   <= cmd_s1.coord_v;
		tx_s3   <= tx_s2;
		ty_s3   <= ty_s2;
		cu_s3   <= cu_s2;
		cv_s3   <= cv_s2;
		ty_s4   <= ty_s3;
		cu_s4   <= cu_s3;
		cv_s4   <= cv_s3;
		cu_s5   <= cu_s4;
		cv_s5   <= cv_s4;
		res_s6.warped_u <= cu_s5 + {fx_s5, {fgbw_pkg::DispShift{1'b0}}};
		res_s6.warped_v <= cv_s5 + {fy_s5, {fgbw_pkg::DispShift{1'b0}}};
	end

	fgbw_axis #(
		.SIZE      (GRID_WIDTH),
		.IDX_WIDTH (XWidth)
	) u_axis_x (
		.clk   (clk),
		.coord (cmd_s1.coord_u),
		.g0    (gx0_s2),
		.g1    (gx1_s2),
		.frac  (tx_s2)
	);

	fgbw_axis #(
		.SIZE      (GRID_HEIGHT),
		.IDX_WIDTH (YWidth)
	) u_axis_y (
		.clk   (clk),
		.coord (cmd_s1.coord_v),
		.g0    (gy0_s2),
		.g1    (gy1_s2),
		.frac  (ty_s2)
	);

	// writes are applied in the read stage so that command order holds
	always_comb begin
		wr_en   = v_s2 && (func_s2 == fgbw_pkg::FuncWrite)
			&& (32'(idx_s2) < 32'(CellCount));
		wr_addr = AddrWidth'(idx_s2);
		wr_data = {dy_s2, dx_s2};
		rd_addr[0] = AddrWidth'(AddrWidth'(gy0_s2) * AddrWidth'(GRID_WIDTH)
			+ AddrWidth'(gx0_s2));
		rd_addr[1] = AddrWidth'(AddrWidth'(gy0_s2) * AddrWidth'(GRID_WIDTH)
			+ AddrWidth'(gx1_s2));
		rd_addr[2] = AddrWidth'(AddrWidth'(gy1_s2) * AddrWidth'(GRID_WIDTH)
			+ AddrWidth'(gx0_s2));
		rd_addr[3] = AddrWidth'(AddrWidth'(gy1_s2) * AddrWidth'(GRID_WIDTH)
			+ AddrWidth'(gx1_s2));
	end

	for (genvar gi = 0; gi < 4; gi++) begin : g_copy
		fgbw_mem #(
			.DEPTH      (CellCount),
			.ADDR_WIDTH (AddrWidth),
			.DATA_WIDTH (EntryBits)
		) u_mem (
			.clk     (clk),
			.wr_en   (wr_en),
			.wr_addr (wr_addr),
			.wr_data (wr_data),
			.rd_addr (rd_addr[gi]),
			.rd_data (rd_data[gi])
		);
	end

	// corners: 0 = (x0,y0), 1 = (x1,y0), 2 = (x0,y1), 3 = (x1,y1)
	fgbw_lerp u_top_x (
		.clk (clk),
		.a   (rd_data[0][DW-1:0]),
		.b   (rd_data[1][DW-1:0]),
		.t   (tx_s3),
		.y   (top_x_s4)
	);

	fgbw_lerp u_top_y (
		.clk (clk),
		.a   (rd_data[0][EntryBits-1:DW]),
		.b   (rd_data[1][EntryBits-1:DW]),
		.t   (tx_s3),
		.y   (top_y_s4)
	);

	fgbw_lerp u_bot_x (
		.clk (clk),
		.a   (rd_data[2][DW-1:0]),
		.b   (rd_data[3][DW-1:0]),
		.t   (tx_s3),
		.y   (bot_x_s4)
	);

	fgbw_lerp u_bot_y (
		.clk (clk),
		.a   (rd_data[2][EntryBits-1:DW]),
		.b   (rd_data[3][EntryBits-1:DW]),
		.t   (tx_s3),
		.y   (bot_y_s4)
	);

	fgbw_lerp u_mix_x (
		.clk (clk),
		.a   (top_x_s4),
		.b   (bot_x_s4),
		.t   (ty_s4),
		.y   (fx_s5)
	);

	fgbw_lerp u_mix_y (
		.clk (clk),
		.a   (top_y_s4),
		.b   (bot_y_s4),
		.t   (ty_s4),
		.y   (fy_s5)
	);

	assign result_valid = v_s6;
	assign result       = res_s6;

	`FGBW_ASSERT_NEXT(a_write_no_result, clk, arst_n,
		v_s2 && (func_s2 == fgbw_pkg::FuncWrite), !v_s3)
	`FGBW_ASSERT_PROP(a_sample_latency, clk, arst_n,
		(accept && (cmd.func == fgbw_pkg::FuncSample)) |-> ##6 result_valid)
	`FGBW_ASSERT_NOW(a_result_has_sample, clk, arst_n,
		result_valid, $past(v_s2 && (func_s2 == fgbw_pkg::FuncSample), 4))
	`FGBW_ASSERT_NOW(a_x_neighbor, clk, arst_n, v_s2,
		((gx1_s2 == gx0_s2) && (gx0_s2 == XWidth'(GRID_WIDTH - 1)))
		|| (gx1_s2 == XWidth'(gx0_s2 + 1'b1)))

endmodule
